### rtl/b64u_pkg.sv
// ----------------------------------------------------------------------------
// b64u_pkg: shared types and helpers for the URL-safe base64 decoder
// Holds the alphabet lookup and the structs passed between the decode core
// and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package b64u_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned SextetW  = 6;
  localparam int unsigned AccW     = 18;
  localparam int unsigned MaxBytes = 3;

  localparam logic [SextetW-1:0] SEXTET_DASH       = 6'h3E;
  localparam logic [SextetW-1:0] SEXTET_UNDERSCORE = 6'h3F;

  // Sextet lookup result: hit is low for characters outside the alphabet.
  typedef struct packed {
    logic               hit;
    logic [SextetW-1:0] value;
  } sextet_t;

  // All results caused by one item, at most three of them.
  typedef struct packed {
    logic [1:0]                   count;   // number of results, 0..3
    logic [MaxBytes-1:0][CharW-1:0] bytes; // entry 0 is delivered first
    logic                         marker;  // single empty end marker
    logic                         last;    // final result carries end_of_text
  } group_t;

  // Decoder state visible to the top level for checking.
  typedef struct packed {
    logic [1:0] sextet_count;
    logic       pad_seen;
  } core_status_t;

  function automatic sextet_t sextet_of(input logic [CharW-1:0] c);
    sextet_t r;
    r.hit   = 1'b1;
    r.value = '0;
    case (c) inside
      [8'h41:8'h5A]: r.value = SextetW'(c - 8'h41);
      [8'h61:8'h7A]: r.value = SextetW'(c - 8'h61 + 8'd26);
      [8'h30:8'h39]: r.value = SextetW'(c - 8'h30 + 8'd52);
      8'h2D:         r.value = SEXTET_DASH;
      8'h5F:         r.value = SEXTET_UNDERSCORE;
      default:       r.hit   = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/b64u_core.sv
// ----------------------------------------------------------------------------
// b64u_core: sextet accumulator and group builder
// Turns one registered character into its group of results and advances the
// accumulator, sextet count and pad flag when the group is handed on.
// ----------------------------------------------------------------------------
`default_nettype none

module b64u_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      advance,
  input  wire logic [7:0]                in_char,
  input  wire logic                      is_last,
  input  wire logic [7:0]                pad_character,
  output b64u_pkg::group_t               group,
  output b64u_pkg::core_status_t         status
);

  logic [1:0]  sextet_count;
  logic [1:0]  sextet_count_next;
  logic [17:0] group_accumulator;
  logic [17:0] group_accumulator_next;
  logic        pad_seen;
  logic        pad_seen_next;

  b64u_pkg::sextet_t sx;
  logic              pad_hit;
  logic              take;
  logic [23:0]       full;

  always_comb begin
    sx      = b64u_pkg::sextet_of(in_char);
    pad_hit = !pad_seen && (pad_character != 8'h00) && (in_char == pad_character);
    take    = !pad_seen && !pad_hit && sx.hit;
    full    = {group_accumulator, sx.value};

    group                  = '0;
    group.last             = is_last;
    sextet_count_next      = sextet_count;
    group_accumulator_next = group_accumulator;
    pad_seen_next          = pad_seen || pad_hit;

    if (take && (sextet_count == 2'd3)) begin
      group.count            = 2'd3;
      group.bytes[0]         = full[23:16];
      group.bytes[1]         = full[15:8];
      group.bytes[2]         = full[7:0];
      sextet_count_next      = 2'd0;
      group_accumulator_next = '0;
    end else if (take) begin
      group_accumulator_next = {group_accumulator[11:0], sx.value};
      sextet_count_next      = sextet_count + 2'd1;
    end

    if (is_last) begin
      // Flush a partial group; a lone sextet carries no whole byte.
      if (sextet_count_next == 2'd2) begin
        group.count    = 2'd1;
        group.bytes[0] = group_accumulator_next[11:4];
      end else if (sextet_count_next == 2'd3) begin
        group.count    = 2'd2;
        group.bytes[0] = group_accumulator_next[17:10];
        group.bytes[1] = group_accumulator_next[9:2];
      end
      if (group.count == 2'd0) begin
        group.count  = 2'd1;
        group.marker = 1'b1;
      end
      sextet_count_next      = 2'd0;
      group_accumulator_next = '0;
      pad_seen_next          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_count      <= 2'd0;
      group_accumulator <= '0;
      pad_seen          <= 1'b0;
    end else if (advance) begin
      sextet_count      <= sextet_count_next;
      group_accumulator <= group_accumulator_next;
      pad_seen          <= pad_seen_next;
    end
  end

  assign status.sextet_count = sextet_count;
  assign status.pad_seen     = pad_seen;

endmodule

`default_nettype wire

### rtl/base64url_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64url_stream_decoder: URL-safe base64 decoder, one character per item
// Path: an item waits in the input register, then its results leave the result buffer.
// Throughput: one item per cycle unless an item waits. An item that gives results waits
// in the input register until the result buffer is empty or its last result is taken.
// Items that give no result pass the buffer at once, so four characters fit three outputs.
// Reset (rst, synchronous): clears the pad register, decoder state and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module base64url_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  // Character channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic       is_last,
  // Result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            end_of_text,
  // Configuration channel: the pad character
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  // The pad register. Writes are always taken; the user must write only while
  // the decoder is idle; the block does not enforce it and has no data path interlock.
  logic [7:0] pad_character;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_character <= 8'h00;
    end else if (cfg_valid) begin
      pad_character <= cfg_data;
    end
  end

  // Input register. The character sits here while the decode core works out
  // its results, and moves on once the result buffer can take them.
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       load;
  logic       fill;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && in_ready;
  assign in_ready = !s1_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char <= in_char;
      s1_last <= is_last;
    end
  end

  b64u_pkg::group_t       group;
  b64u_pkg::core_status_t status;

  b64u_core u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (load),
    .in_char       (s1_char),
    .is_last       (s1_last),
    .pad_character (pad_character),
    .group         (group),
    .status        (status)
  );

  // Result buffer. It holds the remaining results of one item; entry 0 is the
  // one on offer and the rest shift down as each result is taken. A group with
  // results may load when the buffer is empty or its last result leaves this
  // cycle. A character that gives no result only advances the decoder state,
  // so it moves on at once and leaves the buffer untouched.
  logic [1:0]       rem;
  logic [2:0][7:0]  buf_bytes;
  logic             buf_marker;
  logic             buf_last;

  assign out_take = out_valid && out_ready;
  assign load     = s1_valid && ((group.count == 2'd0) || (rem == 2'd0) ||
                                 ((rem == 2'd1) && out_ready));
  assign fill     = load && (group.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (fill) begin
      rem <= group.count;
    end else if (out_take) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      buf_bytes  <= group.bytes;
      buf_marker <= group.marker;
      buf_last   <= group.last;
    end else if (out_take) begin
      buf_bytes  <= {8'h00, buf_bytes[2:1]};
    end
  end

  assign out_valid   = (rem != 2'd0);
  assign out_byte    = buf_bytes[0];
  assign byte_valid  = !buf_marker;
  // Only the final result of the item that carried the last flag is marked.
  assign end_of_text = buf_last && (rem == 2'd1);

  // The empty marker is only ever the final result of a text.
  a_marker_is_final : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (end_of_text && rem == 2'd1))
    else $error("empty marker offered without end of text");

  // Once the last character of a text has been decoded, the decoder state is clear.
  a_state_clear_at_end : assert property (@(posedge clk) disable iff (rst)
    (load && s1_last) |=> (status.sextet_count == 2'd0 && !status.pad_seen))
    else $error("decoder state not cleared at end of text");

  // A group only loads into an empty buffer or one that is draining its last result.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    fill |-> (rem == 2'd0 || (rem == 2'd1 && out_take)))
    else $error("result buffer overwritten");

  // The input register empties when it hands a group on and takes no new item.
  a_s1_drains : assert property (@(posedge clk) disable iff (rst)
    (load && !in_take) |=> !s1_valid)
    else $error("input register kept a consumed item");

endmodule

`default_nettype wire
